// File: rtl/core/sha_pkg.sv
// SHA-256 stream core package: types, constants and round functions.
// Used by all modules of the core; no dependencies.
package sha_pkg;

   localparam int unsigned QueueDepth = 4;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } state_type;

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
      32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
      32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
      32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
      32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
      32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
      32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
      32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
      32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
      32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
      32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   localparam logic [31:0] InitChain [8] = '{
      32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
      32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenPos  = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// File: rtl/core/sha_queue.sv
// Small FIFO between the intake side and the hash engine.
// Depends on sha_pkg.
module sha_queue import sha_pkg::*; #(
   parameter int unsigned Depth = QueueDepth
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);
   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

   item_type          mem_ff [Depth];
   logic [AW-1:0]     wr_ff, rd_ff;
   logic [AW:0]       cnt_ff;
   logic              push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule

// File: rtl/core/sha_engine.sv
// Hash engine: bytes packed into the schedule registers, one round per cycle, padding, digest output.
// Depends on sha_pkg.
module sha_engine import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_word,
   output logic [2:0]  out_index,
   output logic        out_done
);
   state_type   state_ff, state_in;
   logic [31:0] chain_ff [8];
   logic [31:0] work_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  fill_ff;
   logic [60:0] len_ff;
   logic [5:0]  rnd_ff;
   logic        last_ff;   // block being hashed is the final one
   logic        second_ff; // padding needs one more block
   logic        padded_ff; // padding already started for this message
   logic [2:0]  oidx_ff;

   logic [31:0] t1, t2, wnew, wcur;
   logic [63:0] bits;
   logic [31:0] pad_blk [16];

   assign bits      = {len_ff, 3'b000};
   assign wcur      = w_ff[0];
   assign wnew      = sig1(w_ff[14]) + w_ff[9] + sig0(w_ff[1]) + w_ff[0];
   assign t1        = work_ff[7] + (rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11)
                      ^ rotr(work_ff[4], 25)) + ((work_ff[4] & work_ff[5])
                      ^ (~work_ff[4] & work_ff[6])) + RoundConst[rnd_ff] + wcur;
   assign t2        = (rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22))
                      + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                      ^ (work_ff[1] & work_ff[2]));
   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign out_word  = chain_ff[oidx_ff];
   assign out_index = oidx_ff;
   assign out_done  = (oidx_ff == 3'd7);

   // pad byte goes in once; zeros plus the bit length otherwise on the extra pass
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         for (int j = 0; j < 4; j++) begin
            if (second_ff || 6'(4*i + j) > fill_ff) begin
               pad_blk[i][8*(3-j) +: 8] = 8'h00;
            end else if (6'(4*i + j) == fill_ff) begin
               pad_blk[i][8*(3-j) +: 8] = PadByte;
            end else begin
               pad_blk[i][8*(3-j) +: 8] = w_ff[i][8*(3-j) +: 8];
            end
         end
      end
      if (second_ff || fill_ff < LenPos) begin
         pad_blk[14] = bits[63:32];
         pad_blk[15] = bits[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (in_item.present && fill_ff == 6'd63) begin
                  state_in = ST_LOAD;
               end else if (in_item.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_LOAD:  state_in = ST_ROUND;
         ST_ROUND: if (rnd_ff == 6'd63) state_in = ST_ADD;
         ST_ADD: begin
            if (second_ff || (last_ff && !padded_ff)) begin
               state_in = ST_PAD;
            end else if (last_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD:   state_in = ST_LOAD;
         ST_OUT:   if (out_ready && oidx_ff == 3'd7) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         len_ff    <= '0;
         rnd_ff    <= '0;
         last_ff   <= 1'b0;
         second_ff <= 1'b0;
         padded_ff <= 1'b0;
         oidx_ff   <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= InitChain[i];
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  if (in_item.present) begin
                     w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= in_item.data;
                     fill_ff <= fill_ff + 1'b1;
                     len_ff  <= len_ff + 1'b1;
                  end
                  last_ff   <= in_item.last;
                  second_ff <= 1'b0;
                  padded_ff <= 1'b0;
               end
            end
            ST_PAD: begin
               for (int i = 0; i < 16; i++) w_ff[i] <= pad_blk[i];
               if (second_ff || fill_ff < LenPos) begin
                  second_ff <= 1'b0;
               end else begin
                  second_ff <= 1'b1;
               end
               padded_ff <= 1'b1;
               fill_ff   <= '0;
            end
            ST_LOAD: begin
               for (int i = 0; i < 8; i++) work_ff[i] <= chain_ff[i];
               rnd_ff <= '0;
            end
            ST_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15]   <= wnew;
               work_ff[7] <= work_ff[6];
               work_ff[6] <= work_ff[5];
               work_ff[5] <= work_ff[4];
               work_ff[4] <= work_ff[3] + t1;
               work_ff[3] <= work_ff[2];
               work_ff[2] <= work_ff[1];
               work_ff[1] <= work_ff[0];
               work_ff[0] <= t1 + t2;
               rnd_ff     <= rnd_ff + 1'b1;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + work_ff[i];
               oidx_ff <= '0;
            end
            ST_OUT: begin
               if (out_ready) begin
                  oidx_ff <= oidx_ff + 1'b1;
                  if (oidx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) chain_ff[i] <= InitChain[i];
                     len_ff  <= '0;
                     fill_ff <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// File: rtl/core/sha256_stream_hash_core.sv
// Streaming SHA-256 core: byte intake queue feeding a one-round-per-cycle engine.
// Each 64th byte starts a block pass in the engine: load, 64 rounds, add.
// Final item: pad and one or two blocks, then 8 digest transfers.
// The single shared round unit limits the byte rate: while it hashes a block, bytes wait in the queue.
// Reset (synchronous, active high) empties the queue and loads the initial hash values.
// Depends on sha_pkg, sha_queue, sha_engine.
module sha256_stream_hash_core import sha_pkg::*; #(
   parameter int unsigned QDepth = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_message_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_done
);
   item_type req_item, q_item;
   logic     q_valid, q_ready;

   assign req_item = '{data: req_message_byte, present: req_byte_present,
                       last: req_end_of_message};

   sha_queue #(.Depth(QDepth)) u_queue (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_item(req_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));

   sha_engine u_engine (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_word(rsp_digest_word), .out_index(rsp_word_index),
      .out_done(rsp_digest_done));
endmodule
